// ===== src/windowed_mean_min_max_tracker_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the windowed mean / min / max tracker
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_MEAN_MIN_MAX_TRACKER_ASSERT_SVH
`define WINDOWED_MEAN_MIN_MAX_TRACKER_ASSERT_SVH

// Invariant that holds at every clock edge.
`define WMMT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define WMMT_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/wmmt_pkg.sv =====
// ----------------------------------------------------------------------------
// wmmt_pkg
// Shared constants and types of the windowed mean / min / max tracker.
// ----------------------------------------------------------------------------
package wmmt_pkg;

  localparam int unsigned MAX_WINDOW_DEF  = 256;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned TCNT_W     = 32;
  localparam int unsigned OP_W       = 2;

  localparam logic [TCNT_W-1:0] THRESH_NONE = 32'hFFFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_MMRST  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WLEN   = 1'b0,
    CFG_THRESH = 1'b1
  } cfg_idx_e;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_APPEND = 9'b000000010,
    ST_SCAN   = 9'b000000100,
    ST_MERGE  = 9'b000001000,
    ST_EVICT  = 9'b000010000,
    ST_WRITE  = 9'b000100000,
    ST_DIVGO  = 9'b001000000,
    ST_DIVW   = 9'b010000000,
    ST_DONE   = 9'b100000000
  } st_e;

endpackage

// ===== src/wmmt_store.sv =====
// ----------------------------------------------------------------------------
// wmmt_store
// Sample window memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wmmt_store #(
  parameter  int unsigned DEPTH = 256,
  parameter  int unsigned DW    = 16,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/wmmt_div.sv =====
// ----------------------------------------------------------------------------
// wmmt_div
// Bit-serial signed-by-unsigned divider, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module wmmt_div #(
  parameter int unsigned DVD_W = 24,
  parameter int unsigned DVS_W = 9
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DVD_W-1:0] dividend_i,
  input  logic        [DVS_W-1:0] divisor_i,
  output logic                    done_o,
  output logic signed [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic             neg_q;

  logic [DVD_W-1:0] mag;
  logic [DVS_W:0]   trial, diff;
  logic             fits;

  assign mag   = dividend_i[DVD_W-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(DVD_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // One quotient bit per cycle: shift in, try subtract, keep if it fits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= mag;
      rem_q <= '0;
      dvs_q <= divisor_i;
      neg_q <= dividend_i[DVD_W-1];
    end else if (busy_q) begin
      rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

// ===== src/windowed_mean_min_max_tracker.sv =====
// ----------------------------------------------------------------------------
// windowed_mean_min_max_tracker
// Sliding-window mean, sum, minimum and maximum over a stream of samples.
// ----------------------------------------------------------------------------
// One result beat leaves for every input beat. An append takes longer than a
// clear, a min/max reset or an unused op (less long into an empty window), and
// longer still when the oldest sample is evicted or when a pending min/max
// reset forces a rescan of the window. The time is set by the bit-serial
// divider that forms the mean (one quotient bit per cycle over the SUM_W-bit
// sum) and, on a rescan, by the single read port of the window memory, which
// delivers one held sample per cycle. The result sits in an output register,
// so the next input beat is taken while it waits. The window memory needs no
// clearing pass: only held samples are ever read.
// Configuration writes are taken whenever the sequencer is idle.
// ----------------------------------------------------------------------------
`include "windowed_mean_min_max_tracker_assert.svh"

module windowed_mean_min_max_tracker
  import wmmt_pkg::*;
#(
  parameter  int unsigned MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter  int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int unsigned AW          = $clog2(MAX_WINDOW),
  localparam int unsigned FILL_W      = $clog2(MAX_WINDOW + 1),
  localparam int unsigned SUM_W       = SAMPLE_BITS + AW,
  localparam int unsigned IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS    = 3 * SAMPLE_BITS + SUM_W + FILL_W + 2 + TCNT_W,
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // sample beats
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // sample
  input  logic [OP_W-1:0]        s_axis_tuser,  // op
  // result beats
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // mean, minimum, maximum, window_sum, fill_count, is_full, is_empty,
  // minmax_count
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // register writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam logic [AW:0]       MaxSlot = (AW + 1)'(MAX_WINDOW);
  localparam logic [FILL_W-1:0] MaxLen  = FILL_W'(MAX_WINDOW);

  // Wrap an offset from the oldest slot around the circular store.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= MaxSlot) begin
      s = s - MaxSlot;
    end
    return s[AW-1:0];
  endfunction

  st_e st_q, st_d;

  logic signed [SAMPLE_BITS-1:0] samp_q, samp_d;
  logic        [AW-1:0]          ptr_q, ptr_d;
  logic        [FILL_W-1:0]      held_q, held_d;
  logic signed [SUM_W-1:0]       sum_q, sum_d;
  logic signed [SAMPLE_BITS-1:0] min_q, min_d, max_q, max_d;
  logic        [TCNT_W-1:0]      tcnt_q, tcnt_d;
  logic                          rescan_q, rescan_d;
  logic        [FILL_W-1:0]      wlen_q, wlen_d;
  logic        [TCNT_W-1:0]      thresh_q, thresh_d;
  logic        [FILL_W-1:0]      scan_rd_q, scan_rd_d;
  logic                          scan_vld_q, scan_vld_d;
  logic                          scan_first_q, scan_first_d;

  logic                          out_vld_q, out_vld_d;
  logic [OUT_TDATA_W-1:0]        out_data_q, out_data_d;
  logic                          out_load;

  logic                          mem_wr_en, mem_rd_en;
  logic [AW-1:0]                 mem_wr_addr, mem_rd_addr;
  logic signed [SAMPLE_BITS-1:0] mem_rd_data;

  logic                          div_start, div_done;
  logic [FILL_W-1:0]             div_divisor;
  logic signed [SUM_W-1:0]       div_quo;

  logic [SUM_W-1:0]              samp_ext, rd_ext;

  assign samp_ext = {{(SUM_W - SAMPLE_BITS){samp_q[SAMPLE_BITS-1]}}, samp_q};
  assign rd_ext   = {{(SUM_W - SAMPLE_BITS){mem_rd_data[SAMPLE_BITS-1]}}, mem_rd_data};

  // Configuration has priority; both only move while the sequencer idles.
  assign cfg_ready_o   = (st_q == ST_IDLE);
  assign s_axis_tready = (st_q == ST_IDLE) && !cfg_valid_i;

  always_comb begin
    logic [FILL_W-1:0] len_v;
    logic [TCNT_W-1:0] thr_v;

    st_d         = st_q;
    samp_d       = samp_q;
    ptr_d        = ptr_q;
    held_d       = held_q;
    sum_d        = sum_q;
    min_d        = min_q;
    max_d        = max_q;
    tcnt_d       = tcnt_q;
    rescan_d     = rescan_q;
    wlen_d       = wlen_q;
    thresh_d     = thresh_q;
    scan_rd_d    = scan_rd_q;
    scan_vld_d   = scan_vld_q;
    scan_first_d = scan_first_q;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = slot(ptr_q, scan_rd_q[AW-1:0]);
    mem_wr_en    = 1'b0;
    mem_wr_addr  = slot(ptr_q, held_q[AW-1:0]);
    div_start    = 1'b0;
    out_load     = 1'b0;
    len_v        = cfg_data_i[FILL_W-1:0];
    thr_v        = cfg_data_i[TCNT_W-1:0];

    case (st_q)
      ST_IDLE: begin
        if (cfg_valid_i) begin
          case (cfg_idx_e'(cfg_index_i))
            CFG_WLEN: begin
              // Ignore zero; saturate; a real change clears the window and the min/max state.
              if (len_v != '0) begin
                if (len_v > MaxLen) begin
                  len_v = MaxLen;
                end
                if (len_v != wlen_q) begin
                  wlen_d   = len_v;
                  sum_d    = '0;
                  held_d   = '0;
                  ptr_d    = '0;
                  rescan_d = 1'b1;
                  tcnt_d   = '0;
                  min_d    = '0;
                  max_d    = '0;
                end
              end
            end
            CFG_THRESH: begin
              if (thr_v == '0) begin
                thr_v = THRESH_NONE;
              end
              if (thr_v != thresh_q) begin
                thresh_d = thr_v;
                rescan_d = 1'b1;
                tcnt_d   = '0;
                if (held_q == '0) begin
                  min_d = '0;
                  max_d = '0;
                end
              end
            end
            default: ;
          endcase
        end else if (s_axis_tvalid) begin
          samp_d = s_axis_tdata[SAMPLE_BITS-1:0];
          case (op_e'(s_axis_tuser))
            OP_APPEND: begin
              // Automatic min/max reset once the count reaches the threshold.
              if (thresh_q <= tcnt_q) begin
                rescan_d = 1'b1;
                tcnt_d   = '0;
              end
              st_d = ST_APPEND;
            end
            OP_CLEAR: begin
              sum_d    = '0;
              held_d   = '0;
              ptr_d    = '0;
              rescan_d = 1'b1;
              tcnt_d   = '0;
              min_d    = '0;
              max_d    = '0;
              st_d     = ST_DIVGO;
            end
            OP_MMRST: begin
              rescan_d = 1'b1;
              tcnt_d   = '0;
              if (held_q == '0) begin
                min_d = '0;
                max_d = '0;
              end
              st_d = ST_DIVGO;
            end
            default: begin
              st_d = ST_DIVGO;
            end
          endcase
        end
      end

      ST_APPEND: begin
        if (held_q == '0) begin
          min_d    = samp_q;
          max_d    = samp_q;
          rescan_d = 1'b0;
          st_d     = ST_WRITE;
        end else if (rescan_q) begin
          scan_rd_d    = '0;
          scan_vld_d   = 1'b0;
          scan_first_d = 1'b1;
          st_d         = ST_SCAN;
        end else begin
          st_d = ST_MERGE;
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle, fold each returning sample in the cycle after its read.
        if (scan_rd_q != held_q) begin
          mem_rd_en = 1'b1;
          scan_rd_d = scan_rd_q + 1'b1;
        end
        scan_vld_d = (scan_rd_q != held_q);
        if (scan_vld_q) begin
          if (scan_first_q) begin
            min_d        = mem_rd_data;
            max_d        = mem_rd_data;
            scan_first_d = 1'b0;
          end else begin
            if (mem_rd_data < min_q) begin
              min_d = mem_rd_data;
            end
            if (mem_rd_data > max_q) begin
              max_d = mem_rd_data;
            end
          end
        end
        if ((scan_rd_q == held_q) && !scan_vld_q) begin
          tcnt_d   = tcnt_q + TCNT_W'(held_q);
          rescan_d = 1'b0;
          st_d     = ST_MERGE;
        end
      end

      ST_MERGE: begin
        if (samp_q > max_q) begin
          max_d = samp_q;
        end
        if (samp_q < min_q) begin
          min_d = samp_q;
        end
        if (held_q >= wlen_q) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = ptr_q;
          st_d        = ST_EVICT;
        end else begin
          st_d = ST_WRITE;
        end
      end

      ST_EVICT: begin
        sum_d  = sum_q - rd_ext;
        ptr_d  = slot(ptr_q, AW'(1));
        held_d = held_q - 1'b1;
        st_d   = ST_WRITE;
      end

      ST_WRITE: begin
        mem_wr_en = 1'b1;
        held_d    = held_q + 1'b1;
        sum_d     = sum_q + samp_ext;
        tcnt_d    = tcnt_q + 1'b1;
        st_d      = ST_DIVGO;
      end

      ST_DIVGO: begin
        div_start = 1'b1;
        st_d      = ST_DIVW;
      end

      ST_DIVW: begin
        if (div_done) begin
          st_d = ST_DONE;
        end
      end

      ST_DONE: begin
        // Hold until the output register is free.
        if (!out_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          st_d     = ST_IDLE;
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Output register: pack from the lowest field up.
  always_comb begin
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_data_d = out_data_q;
    if (out_load) begin
      out_vld_d  = 1'b1;
      out_data_d = OUT_TDATA_W'({tcnt_q,
                                 (held_q == '0),
                                 (held_q == wlen_q),
                                 held_q,
                                 sum_q,
                                 max_q,
                                 min_q,
                                 div_quo[SAMPLE_BITS-1:0]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      ptr_q      <= '0;
      held_q     <= '0;
      sum_q      <= '0;
      min_q      <= '0;
      max_q      <= '0;
      tcnt_q     <= '0;
      rescan_q   <= 1'b1;
      wlen_q     <= MaxLen;
      thresh_q   <= THRESH_NONE;
      scan_rd_q  <= '0;
      scan_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      st_q       <= st_d;
      ptr_q      <= ptr_d;
      held_q     <= held_d;
      sum_q      <= sum_d;
      min_q      <= min_d;
      max_q      <= max_d;
      tcnt_q     <= tcnt_d;
      rescan_q   <= rescan_d;
      wlen_q     <= wlen_d;
      thresh_q   <= thresh_d;
      scan_rd_q  <= scan_rd_d;
      scan_vld_q <= scan_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q       <= samp_d;
    scan_first_q <= scan_first_d;
    out_data_q   <= out_data_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // Divide by the fill count, or by one on an empty window.
  assign div_divisor = (held_q == '0) ? FILL_W'(1) : held_q;

  wmmt_store #(
    .DEPTH (MAX_WINDOW),
    .DW    (SAMPLE_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (samp_q),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  wmmt_div #(
    .DVD_W (SUM_W),
    .DVS_W (FILL_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  `WMMT_ASSERT(a_held_le_len, held_q <= wlen_q, "fill count above window length")
  `WMMT_ASSERT_IMPL(a_empty_minmax, (st_q == ST_IDLE) && (held_q == '0), (min_q == '0) && (max_q == '0), "min or max nonzero on empty window")
  `WMMT_ASSERT_IMPL(a_wr_room, mem_wr_en, (st_q == ST_WRITE) && (held_q < wlen_q), "store write without room")
  `WMMT_ASSERT_IMPL(a_div_done, div_done, st_q == ST_DIVW, "divider done outside wait state")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: windowed mean / min / max tracker
// Streams append, clear, min/max-reset and unused-op beats through the block
// under several window lengths and reset thresholds. A cycle-free tracker
// predicts every result beat, and each one is compared field by field. Both
// stream sides idle at random. One phase backs up the result side for a long
// stretch, and one phase makes the sender wait for a full drain.
// ----------------------------------------------------------------------------
module tb;
  import wmmt_pkg::*;

  localparam int SAMPLE_W    = SAMPLE_BITS_DEF;
  localparam int WIN_AW      = $clog2(MAX_WINDOW_DEF);
  localparam int FILL_W      = $clog2(MAX_WINDOW_DEF + 1);
  localparam int SUM_W       = SAMPLE_W + WIN_AW;
  localparam int IN_W        = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_BITS    = 3 * SAMPLE_W + SUM_W + FILL_W + 2 + TCNT_W;
  localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;
  localparam int QUIET_LIMIT = 5000;  // cycles without any accepted beat
  localparam int HOLD_OFF    = 400;   // long result-side stall, in cycles

  // Op code with no function: the block only reports its state.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [IN_W-1:0] sample;
    bit              wait_drain;  // hold this beat until all results are in
  } sample_beat_t;

  typedef struct {
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [SUM_W-1:0]    total;
    logic [FILL_W-1:0]   fill;
    logic                full;
    logic                empty;
    logic [TCNT_W-1:0]   count;
  } window_report_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Tracker state, as the block holds it after reset.
  logic signed [SAMPLE_W-1:0] win_mem [MAX_WINDOW_DEF];
  logic [WIN_AW-1:0]          win_head = '0;
  int                         win_held = 0;
  int                         win_total = 0;
  int                         mm_lo = 0;
  int                         mm_hi = 0;
  logic [TCNT_W-1:0]          mm_count = '0;
  bit                         mm_rescan = 1'b1;
  int                         cfg_len = MAX_WINDOW_DEF;
  logic [TCNT_W-1:0]          cfg_limit = THRESH_NONE;

  sample_beat_t   pending_beats [$];
  window_report_t expected_reports [$];

  bit in_taken, out_taken;      // handshakes seen at the last rising edge
  bit steady_flow;              // no idling on either side
  bit hold_off_request;
  int hold_off_left, send_wait, take_wait;
  int quiet_cycles, error_count, results_checked, register_writes;
  int op_seen [4];
  int auto_resets, peak_fill;

  windowed_mean_min_max_tracker uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Tracker model
  // --------------------------------------------------------------------------

  // Drop the tracked extremes; the next append into a held window rescans it.
  function automatic void mm_restart();
    mm_rescan = 1'b1;
    mm_count  = '0;
    if (win_held == 0) begin
      mm_lo = 0;
      mm_hi = 0;
    end
  endfunction

  function automatic void clear_window();
    win_total = 0;
    win_held  = 0;
    win_head  = '0;
    mm_restart();
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    int                len;
    logic [TCNT_W-1:0] limit;
    len   = data[FILL_W-1:0];
    limit = (data == '0) ? THRESH_NONE : data;
    case (idx)
      CFG_WLEN: begin
        // Zero is ignored; oversized lengths saturate; a change clears.
        if (len != 0) begin
          if (len > MAX_WINDOW_DEF) len = MAX_WINDOW_DEF;
          if (len != cfg_len) begin
            clear_window();
            cfg_len = len;
          end
        end
      end
      CFG_THRESH: begin
        if (limit != cfg_limit) begin
          cfg_limit = limit;
          mm_restart();
        end
      end
      default: ;
    endcase
  endfunction

  // Advance the tracker by one beat and form the report it must produce.
  function automatic window_report_t track_beat(logic [OP_W-1:0] op,
                                                logic [IN_W-1:0] raw);
    window_report_t             rep;
    logic signed [SAMPLE_W-1:0] s;
    logic [WIN_AW-1:0]          slot;
    int                         v, w, quotient;
    s = raw[SAMPLE_W-1:0];
    v = s;
    op_seen[op]++;
    case (op)
      OP_APPEND: begin
        if (cfg_limit <= mm_count) begin
          mm_restart();
          auto_resets++;
        end
        if (win_held == 0) begin
          mm_lo     = v;
          mm_hi     = v;
          mm_rescan = 1'b0;
        end else begin
          // The rescan still sees the sample that is about to be evicted.
          if (mm_rescan) begin
            mm_lo = win_mem[win_head];
            mm_hi = mm_lo;
            for (int i = 1; i < win_held; i++) begin
              slot = win_head + i[WIN_AW-1:0];
              w    = win_mem[slot];
              if (w < mm_lo) mm_lo = w;
              if (w > mm_hi) mm_hi = w;
            end
            mm_count  = mm_count + win_held;
            mm_rescan = 1'b0;
          end
          if (v > mm_hi) mm_hi = v;
          if (v < mm_lo) mm_lo = v;
        end
        if (win_held >= cfg_len && win_held > 0) begin
          win_total = win_total - int'(win_mem[win_head]);
          win_head  = win_head + 1'b1;
          win_held--;
        end
        slot          = win_head + win_held[WIN_AW-1:0];
        win_mem[slot] = s;
        win_held++;
        win_total = win_total + v;
        mm_count  = mm_count + 1'b1;
      end
      OP_CLEAR: clear_window();
      OP_MMRST: mm_restart();
      default: ;
    endcase
    if (win_held > peak_fill) peak_fill = win_held;
    // Integer division truncates toward zero; an empty window divides by one.
    quotient  = win_total / ((win_held == 0) ? 1 : win_held);
    rep.mean  = quotient[SAMPLE_W-1:0];
    rep.lo    = mm_lo[SAMPLE_W-1:0];
    rep.hi    = mm_hi[SAMPLE_W-1:0];
    rep.total = win_total[SUM_W-1:0];
    rep.fill  = win_held[FILL_W-1:0];
    rep.full  = (win_held == cfg_len);
    rep.empty = (win_held == 0);
    rep.count = mm_count;
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic log_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      log_error($sformatf("result %0d: %s is %0h, expected %0h",
                          results_checked, name, got, want));
  endtask

  // Monitor: sample handshakes at the rising edge, predict on every input
  // beat, check every result beat against the oldest prediction.
  always @(posedge clk_i) begin
    window_report_t got, want;
    bit             cfg_taken;
    in_taken  = rst_ni && s_axis_tvalid && s_axis_tready;
    out_taken = rst_ni && m_axis_tvalid && m_axis_tready;
    cfg_taken = rst_ni && cfg_valid_i && cfg_ready_o;
    if (cfg_taken) begin
      apply_register(cfg_index_i, cfg_data_i);
      register_writes++;
    end
    if (in_taken)
      expected_reports.insert(expected_reports.size(),
                              track_beat(s_axis_tuser, s_axis_tdata));
    if (out_taken) begin
      got.mean  = m_axis_tdata[0 +: SAMPLE_W];
      got.lo    = m_axis_tdata[SAMPLE_W +: SAMPLE_W];
      got.hi    = m_axis_tdata[2*SAMPLE_W +: SAMPLE_W];
      got.total = m_axis_tdata[3*SAMPLE_W +: SUM_W];
      got.fill  = m_axis_tdata[3*SAMPLE_W + SUM_W +: FILL_W];
      got.full  = m_axis_tdata[3*SAMPLE_W + SUM_W + FILL_W];
      got.empty = m_axis_tdata[3*SAMPLE_W + SUM_W + FILL_W + 1];
      got.count = m_axis_tdata[3*SAMPLE_W + SUM_W + FILL_W + 2 +: TCNT_W];
      if (expected_reports.size() == 0) begin
        log_error($sformatf("result %0d arrived with nothing expected", results_checked));
      end else begin
        want = expected_reports[0];
        expected_reports.delete(0);
        check_field("mean", got.mean, want.mean);
        check_field("minimum", got.lo, want.lo);
        check_field("maximum", got.hi, want.hi);
        check_field("window_sum", got.total, want.total);
        check_field("fill_count", got.fill, want.fill);
        check_field("is_full", got.full, want.full);
        check_field("is_empty", got.empty, want.empty);
        check_field("minmax_count", got.count, want.count);
      end
      results_checked++;
    end
    // Watchdog: end the run if nothing moves for too long.
    if (in_taken || out_taken || cfg_taken) quiet_cycles = 0;
    else if (rst_ni) quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stream drivers
  // --------------------------------------------------------------------------

  function automatic int draw_wait();
    return steady_flow ? 0 : $urandom_range(0, 10);
  endfunction

  // Sender: hold a beat until taken, then idle for a drawn gap before the next.
  always @(negedge clk_i) begin
    sample_beat_t beat;
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (send_wait > 0) begin
        send_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_beats.size() > 0 &&
                   !(pending_beats[0].wait_drain && expected_reports.size() > 0)) begin
        beat = pending_beats[0];
        pending_beats.delete(0);
        s_axis_tuser  <= beat.op;
        s_axis_tdata  <= beat.sample;
        s_axis_tvalid <= 1'b1;
        send_wait = draw_wait();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall for a drawn number of cycles after every result beat,
  // and for one long stretch when asked.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off_request) begin
        hold_off_left    = HOLD_OFF;
        hold_off_request = 1'b0;
      end
      if (out_taken) take_wait = draw_wait();
      if (hold_off_left > 0) begin
        hold_off_left--;
        m_axis_tready <= 1'b0;
      end else if (take_wait > 0) begin
        take_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  task automatic push_beat(logic [OP_W-1:0] op, logic [IN_W-1:0] sample, bit drain);
    sample_beat_t beat;
    beat.op         = op;
    beat.sample     = sample;
    beat.wait_drain = drain;
    pending_beats.insert(pending_beats.size(), beat);
  endtask

  // Return at a falling edge once every beat is sent and every result is in.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_beats.size() != 0 || expected_reports.size() != 0 ||
           (s_axis_tvalid && !in_taken));
  endtask

  // Only called while the block is idle; one write per handshake.
  task automatic write_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly appends with random content; other_pct percent are clears,
  // min/max resets and unused ops.
  task automatic run_phase(int n, int other_pct, bit steady, bit hold_off, int drain_at);
    logic [OP_W-1:0] op;
    logic [IN_W-1:0] value;
    @(posedge clk_i);
    steady_flow      = steady;
    hold_off_request = hold_off;
    for (int k = 0; k < n; k++) begin
      op    = ($urandom_range(0, 99) < other_pct) ? OP_W'($urandom_range(1, 3)) : OP_APPEND;
      value = IN_W'($urandom());
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       value = 16'h7FFF;
          1:       value = 16'h8000;
          2:       value = 16'h0000;
          default: value = 16'hFFFF;
        endcase
      end
      push_beat(op, value, k == drain_at);
    end
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-window reports, extremes, reset on empty and on held
    // window, rescan, negative mean truncation, clear with a rescan pending.
    @(posedge clk_i);
    push_beat(OP_UNUSED, 16'hFFFF, 1'b0);
    push_beat(OP_MMRST,  16'h1234, 1'b0);
    push_beat(OP_APPEND, 16'h7FFF, 1'b0);
    push_beat(OP_APPEND, 16'h8000, 1'b0);
    push_beat(OP_APPEND, 16'hFFFF, 1'b0);
    push_beat(OP_APPEND, 16'h0000, 1'b0);
    push_beat(OP_MMRST,  16'h0000, 1'b0);
    push_beat(OP_UNUSED, 16'h0000, 1'b0);
    push_beat(OP_APPEND, 16'h0001, 1'b0);
    push_beat(OP_CLEAR,  16'hFFFF, 1'b0);
    push_beat(OP_APPEND, 16'h8000, 1'b0);
    push_beat(OP_APPEND, 16'h8000, 1'b0);
    push_beat(OP_APPEND, 16'h8001, 1'b0);
    push_beat(OP_APPEND, 16'h0003, 1'b0);
    push_beat(OP_MMRST,  16'h5555, 1'b0);
    push_beat(OP_CLEAR,  16'hAAAA, 1'b0);
    push_beat(OP_APPEND, 16'h5555, 1'b0);
    push_beat(OP_APPEND, 16'hAAAA, 1'b0);
    push_beat(OP_APPEND, 16'hFFF9, 1'b0);
    wait_drained();

    // Zero length is ignored; threshold 0 equals the default and changes nothing.
    write_register(CFG_WLEN, 32'd0);
    write_register(CFG_WLEN, 32'd1);
    write_register(CFG_THRESH, 32'd0);
    write_register(CFG_THRESH, 32'd1);
    run_phase(60, 25, 1'b0, 1'b0, -1);

    write_register(CFG_WLEN, 32'd3);
    write_register(CFG_THRESH, 32'd5);
    run_phase(120, 20, 1'b0, 1'b0, -1);

    // Oversized length saturates to the largest window; fill it and evict.
    write_register(CFG_WLEN, 32'd300);
    write_register(CFG_THRESH, 32'hFFFF_FFFF);
    run_phase(270, 0, 1'b0, 1'b0, -1);
    run_phase(30, 30, 1'b0, 1'b0, -1);

    // Back up the result side while the sender keeps offering beats.
    write_register(CFG_WLEN, 32'd8);
    write_register(CFG_THRESH, 32'd2);
    run_phase(100, 15, 1'b1, 1'b1, -1);

    // Midway, hold the sender until every result has come back.
    write_register(CFG_WLEN, 32'd17);
    write_register(CFG_THRESH, 32'd300);
    run_phase(100, 10, 1'b0, 1'b0, 50);

    write_register(CFG_WLEN, 32'd2);
    write_register(CFG_THRESH, 32'd0);
    run_phase(40, 25, 1'b1, 1'b0, -1);

    write_register(CFG_WLEN, 32'd511);
    write_register(CFG_THRESH, 32'd3);
    run_phase(40, 15, 1'b0, 1'b0, -1);

    // Let any stray result surface before closing.
    repeat (64) @(negedge clk_i);
    if (expected_reports.size() != 0)
      log_error($sformatf("%0d results never arrived", expected_reports.size()));
    $display("Run covered %0d appends, %0d clears, %0d min/max resets, %0d unused ops",
             op_seen[OP_APPEND], op_seen[OP_CLEAR], op_seen[OP_MMRST], op_seen[OP_UNUSED]);
    $display("and %0d register writes; %0d results checked, peak fill %0d, %0d auto resets.",
             register_writes, results_checked, peak_fill, auto_resets);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/wmmt_pkg.sv
src/wmmt_store.sv
src/wmmt_div.sv
src/windowed_mean_min_max_tracker.sv
sim/tb.sv
